// ===== design/lru_replacement_tracker_core_defines.svh =====
// Assertion helpers for the LRU replacement tracker.
`ifndef LRU_REPLACEMENT_TRACKER_CORE_DEFINES_SVH
`define LRU_REPLACEMENT_TRACKER_CORE_DEFINES_SVH

// Checked at every rising clock edge outside reset.
`define LRUT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checked at every rising clock edge, reset included.
`define LRUT_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ===== design/lrut_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrut_pkg
// Shared types, codes and defaults of the LRU replacement tracker.
// ----------------------------------------------------------------------------
package lrut_pkg;

   localparam int ENTRIES_DEF      = 16;
   localparam int PAGE_ID_BITS_DEF = 32;

   localparam int FUNC_W   = 2;
   localparam int PAGE_W   = 32;
   localparam int STATUS_W = 3;
   localparam int OCC_W    = 5;

   // operation codes
   localparam logic [FUNC_W-1:0] FUNC_TOUCH  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_EVICT  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_HIT      = 3'd1;
   localparam logic [STATUS_W-1:0] ST_GONE     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_MISSING  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

   // cell update modes
   localparam logic [1:0] MODE_HOLD = 2'd0;
   localparam logic [1:0] MODE_PUSH = 2'd1;  // shift toward the tail up to index
   localparam logic [1:0] MODE_PULL = 2'd2;  // shift toward the head from index

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [PAGE_W-1:0] page_id;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [PAGE_W-1:0]   evicted_page;
      logic [OCC_W-1:0]    occupancy;
   } rsp_type;

   typedef struct packed {
      logic              seek_tail;
      logic [1:0]        mode;
      logic [PAGE_W-1:0] key;
   } cell_ctl_type;

endpackage

// ===== design/lrut_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrut_cell
// One position of the recency chain: holds a page key and its valid bit,
// compares against the broadcast key and shifts with its neighbors.
// ----------------------------------------------------------------------------
module lrut_cell #(
   parameter int KEY_W    = 32,
   parameter int IDX_W    = 4,
   parameter int CELL_IDX = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  lrut_pkg::cell_ctl_type ctl,
   input  logic [IDX_W-1:0]      ctl_idx,
   input  logic                  prev_valid,
   input  logic [KEY_W-1:0]      prev_key,
   input  logic                  next_valid,
   input  logic [KEY_W-1:0]      next_key,
   output logic                  valid,
   output logic [KEY_W-1:0]      key,
   output logic                  match
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

   logic             valid_ff, valid_in;
   logic [KEY_W-1:0] key_ff, key_in;

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      case (ctl.mode)
         lrut_pkg::MODE_PUSH: begin
            if (MY_IDX <= ctl_idx) begin
               valid_in = prev_valid;
               key_in   = prev_key;
            end
         end
         lrut_pkg::MODE_PULL: begin
            if (MY_IDX >= ctl_idx) begin
               valid_in = next_valid;
               key_in   = next_key;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   // tail is the last valid cell of the contiguous valid run
   assign match = ctl.seek_tail ? (valid_ff & ~next_valid)
                                : (valid_ff & (key_ff == ctl.key[KEY_W-1:0]));
   assign valid = valid_ff;
   assign key   = key_ff;

endmodule

// ===== design/lru_replacement_tracker_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_replacement_tracker_core
// LRU order of up to ENTRIES pages kept in a chain of cells, head = most recent.
// ----------------------------------------------------------------------------
// Usage:
//   req_valid/req_ready/req_data carry one operation (touch, evict, remove)
//   and a page id. rsp_valid/rsp_ready/rsp_data return one result per
//   operation: status, the evicted page and the occupancy after it.
//   An operation runs through a lookup step, in which every cell compares
//   its key (or finds the tail) at once, and an apply step, in which the
//   cells shift by one position and the result register loads.
//   The result is registered in the apply step. A new request is taken in
//   the apply step, so operations overlap while the result side keeps up.
//   A result waiting in the output register does not block the next request;
//   that request then waits in its apply cycle until the result is taken.
//   Reset clears all cell valid bits and the occupancy; no clearing pass is
//   needed, the block accepts requests as soon as reset is released.
// ----------------------------------------------------------------------------
`include "lru_replacement_tracker_core_defines.svh"

module lru_replacement_tracker_core #(
   parameter int ENTRIES      = lrut_pkg::ENTRIES_DEF,
   parameter int PAGE_ID_BITS = lrut_pkg::PAGE_ID_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lrut_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lrut_pkg::rsp_type rsp_data
);

   localparam int KEY_W = (PAGE_ID_BITS < lrut_pkg::PAGE_W) ? PAGE_ID_BITS
                                                            : lrut_pkg::PAGE_W;
   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(ENTRIES);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_LOOK  = 2'd1;
   localparam logic [1:0] S_APPLY = 2'd2;

   logic [1:0]              state_ff, state_in;
   lrut_pkg::req_type       req_ff;
   logic [1:0]              mode_ff, mode_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic [lrut_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [KEY_W-1:0]        evict_ff, evict_in;
   logic [CNT_W-1:0]        count_next_ff, count_next_in;
   logic [CNT_W-1:0]        count_ff;
   lrut_pkg::rsp_type       rsp_ff;
   logic                    rsp_valid_ff, rsp_valid_in;

   logic                    req_xfer, apply_go;
   lrut_pkg::cell_ctl_type  ctl;
   logic [KEY_W-1:0]        req_key;

   logic [ENTRIES-1:0]      cell_valid, cell_match;
   logic [KEY_W-1:0]        cell_key [ENTRIES];

   logic                    found;
   logic [IDX_W-1:0]        found_idx;
   logic [KEY_W-1:0]        found_key;

   assign req_key  = req_ff.page_id[KEY_W-1:0];
   assign apply_go = (state_ff == S_APPLY) && (!rsp_valid_ff || rsp_ready);
   assign req_ready = (state_ff == S_IDLE) || apply_go;
   assign req_xfer  = req_valid && req_ready;

   // broadcast to the chain; cells move only in a committed apply cycle
   always_comb begin
      ctl.seek_tail = (req_ff.func == lrut_pkg::FUNC_EVICT);
      ctl.mode      = apply_go ? mode_ff : lrut_pkg::MODE_HOLD;
      ctl.key       = lrut_pkg::PAGE_W'(req_key);
   end

   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      logic             prev_valid, next_valid;
      logic [KEY_W-1:0] prev_key, next_key;

      if (g == 0) begin : g_head
         assign prev_valid = 1'b1;
         assign prev_key   = req_key;
      end else begin : g_mid
         assign prev_valid = cell_valid[g-1];
         assign prev_key   = cell_key[g-1];
      end

      if (g == ENTRIES - 1) begin : g_tail
         assign next_valid = 1'b0;
         assign next_key   = cell_key[g];
      end else begin : g_body
         assign next_valid = cell_valid[g+1];
         assign next_key   = cell_key[g+1];
      end

      lrut_cell #(
         .KEY_W    (KEY_W),
         .IDX_W    (IDX_W),
         .CELL_IDX (g)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .ctl_idx    (idx_ff),
         .prev_valid (prev_valid),
         .prev_key   (prev_key),
         .next_valid (next_valid),
         .next_key   (next_key),
         .valid      (cell_valid[g]),
         .key        (cell_key[g]),
         .match      (cell_match[g])
      );
   end

   // at most one cell matches: OR-reduce its position and key
   always_comb begin
      found     = 1'b0;
      found_idx = '0;
      found_key = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         found     = found | cell_match[i];
         found_idx = found_idx | (IDX_W'(i) & {IDX_W{cell_match[i]}});
         found_key = found_key | (cell_key[i] & {KEY_W{cell_match[i]}});
      end
   end

   // decide the operation in the lookup cycle
   always_comb begin
      mode_in       = lrut_pkg::MODE_HOLD;
      idx_in        = found_idx;
      status_in     = lrut_pkg::ST_MISSING;
      evict_in      = '0;
      count_next_in = count_ff;
      case (req_ff.func)
         lrut_pkg::FUNC_TOUCH: begin
            if (found) begin
               mode_in   = lrut_pkg::MODE_PUSH;
               status_in = lrut_pkg::ST_HIT;
            end else if (count_ff == CNT_FULL) begin
               status_in = lrut_pkg::ST_FULL;
            end else begin
               mode_in       = lrut_pkg::MODE_PUSH;
               idx_in        = IDX_LAST;
               status_in     = lrut_pkg::ST_INSERTED;
               count_next_in = count_ff + 1'b1;
            end
         end
         lrut_pkg::FUNC_EVICT: begin
            if (found) begin
               mode_in       = lrut_pkg::MODE_PULL;
               status_in     = lrut_pkg::ST_GONE;
               evict_in      = found_key;
               count_next_in = count_ff - 1'b1;
            end
         end
         lrut_pkg::FUNC_REMOVE: begin
            if (found) begin
               mode_in       = lrut_pkg::MODE_PULL;
               status_in     = lrut_pkg::ST_GONE;
               count_next_in = count_ff - 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_xfer) state_in = S_LOOK;
         end
         S_LOOK: begin
            state_in = S_APPLY;
         end
         S_APPLY: begin
            if (apply_go) state_in = req_xfer ? S_LOOK : S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (apply_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (apply_go) count_ff <= count_next_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) req_ff <= req_data;
      if (state_ff == S_LOOK) begin
         mode_ff       <= mode_in;
         idx_ff        <= idx_in;
         status_ff     <= status_in;
         evict_ff      <= evict_in;
         count_next_ff <= count_next_in;
      end
      if (apply_go) begin
         rsp_ff.status       <= status_ff;
         rsp_ff.evicted_page <= lrut_pkg::PAGE_W'(evict_ff);
         rsp_ff.occupancy    <= lrut_pkg::OCC_W'(count_next_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `LRUT_ASSERT(a_count_bound, count_ff <= CNT_FULL, "occupancy above capacity")
   `LRUT_ASSERT(a_count_cells, $countones(cell_valid) == count_ff,
                "occupancy differs from valid cells")
   `LRUT_ASSERT(a_valid_prefix, (cell_valid & (cell_valid + 1'b1)) == '0,
                "valid cells not contiguous from the head")
   `LRUT_ASSERT(a_match_unique, state_ff == S_LOOK |-> $onehot0(cell_match),
                "more than one cell matched")
   `LRUT_ASSERT(a_apply_result, apply_go |=> rsp_valid_ff,
                "apply cycle left no result")

endmodule
